[hdl/gng_pkg.sv]
// ----------------------------------------------------------------------------
// gng_pkg: shared types and constants of the gaussian noise generator
// Operation codes, the command beat between front and back, and the constant
// tables for the LCG, the log, the radius scaling and the CORDIC stage.
// ----------------------------------------------------------------------------
package gng_pkg;

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] SEED_RESET = 32'd42;
  localparam logic [32:0] U1_OFFSET  = 33'd4;

  localparam int          LOG_FRAC_BITS = 24;
  localparam logic [30:0] TWO_LN2_Q30   = 31'd1488522236;
  localparam logic [24:0] HALF_PI_Q24   = 25'd26353589;
  localparam int          CORDIC_ITERS  = 20;
  localparam logic signed [27:0] CORDIC_GAIN_Q24 = 28'sd10188014;

  // Command beat from front to back: the two generator words of a draw,
  // or a reseed marker.
  typedef struct packed {
    logic        reseed;
    logic [31:0] w1;
    logic [31:0] w2;
  } gng_cmd_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] w);
    logic [63:0] p;
    p = w * LCG_MUL;
    return p[31:0] + LCG_ADD;
  endfunction

  function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0:  return 28'sd13176795;
      5'd1:  return 28'sd7778716;
      5'd2:  return 28'sd4110060;
      5'd3:  return 28'sd2086331;
      5'd4:  return 28'sd1047214;
      5'd5:  return 28'sd524117;
      5'd6:  return 28'sd262123;
      5'd7:  return 28'sd131069;
      5'd8:  return 28'sd65536;
      5'd9:  return 28'sd32768;
      5'd10: return 28'sd16384;
      5'd11: return 28'sd8192;
      5'd12: return 28'sd4096;
      5'd13: return 28'sd2048;
      5'd14: return 28'sd1024;
      5'd15: return 28'sd512;
      5'd16: return 28'sd256;
      5'd17: return 28'sd128;
      5'd18: return 28'sd64;
      5'd19: return 28'sd32;
      default: return 28'sd0;
    endcase
  endfunction

endpackage

[hdl/gng_front.sv]
// ----------------------------------------------------------------------------
// gng_front: input side of the gaussian noise generator
// Holds the generator word, steps it twice per draw and loads it on reseed.
// ----------------------------------------------------------------------------
module gng_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            op,
  input  logic [31:0]     seed_value,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output gng_pkg::gng_cmd_t cmd
);
  import gng_pkg::*;

  logic [31:0] word;
  logic [31:0] w1_step;
  logic [31:0] w2_step;

  assign w1_step = lcg_next(word);
  assign w2_step = lcg_next(w1_step);

  // Single holding register toward the queue.
  assign full = cmd_valid && !cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word      <= SEED_RESET;
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= (push && !full) || (cmd_valid && !cmd_ready);
      if (push && !full) begin
        if (op == OP_RESEED) begin
          word       <= seed_value;
          cmd.reseed <= 1'b1;
        end else begin
          word       <= w2_step;
          cmd.reseed <= 1'b0;
        end
        cmd.w1 <= w1_step;
        cmd.w2 <= w2_step;
      end
    end
  end

endmodule

[hdl/gng_queue.sv]
// ----------------------------------------------------------------------------
// gng_queue: two-entry queue between front and back
// Decouples command generation from the long sample computation.
// ----------------------------------------------------------------------------
module gng_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gng_pkg::gng_cmd_t in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output gng_pkg::gng_cmd_t out_cmd
);
  import gng_pkg::*;

  gng_cmd_t    mem [2];
  logic        wp, rp;
  logic [1:0]  count;
  logic        wr, rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = mem[rp];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_cmd;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[hdl/gng_back.sv]
// ----------------------------------------------------------------------------
// gng_back: sample computation of the gaussian noise generator
// Sequencer: log by repeated squaring, radius scale, bit-serial square root,
// CORDIC cosine, final product and rounding, one item at a time.
// ----------------------------------------------------------------------------
module gng_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  gng_pkg::gng_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [15:0]       res_sample
);
  import gng_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_LOG, S_LOGFIN, S_RAD, S_SQRT, S_CORDIC, S_MUL, S_RND, S_OUT
  } state_t;

  state_t             state;
  logic [32:0]        x;
  logic [5:0]         k;
  logic [32:0]        m;
  logic [23:0]        frac;
  logic [4:0]         cnt;
  logic [29:0]        t;
  logic [55:0]        r2;
  logic [28:0]        res;
  logic [55:0]        rem;
  logic signed [27:0] cx, cy, cz;
  logic [1:0]         quad;
  logic [31:0]        w2;
  logic [27:0]        cabs;
  logic               cneg;
  logic [56:0]        prod;
  logic               zero_out;

  logic [65:0] m_sq;
  logic [60:0] t_mul;
  logic [57:0] trial;
  logic [54:0] th_mul;
  logic signed [27:0] sx, sy;
  logic [15:0] out_val;

  assign m_sq  = m * m;
  assign t_mul = t * TWO_LN2_Q30;
  assign trial = {rem, 2'b00} | {30'd0, r2[55:54]};
  assign th_mul = w2[29:0] * HALF_PI_Q24;
  assign sx = cx >>> cnt;
  assign sy = cy >>> cnt;
  assign cmd_ready = (state == S_IDLE);

  // Round, saturate and sign the magnitude; zero for reseed and top of range.
  assign out_val = zero_out ? 16'd0 :
                   cneg ? ((prod[56:36] > 21'd32768) ? 16'h8000 : 16'(-prod[51:36])) :
                          ((prod[56:36] > 21'd32767) ? 16'h7fff : prod[51:36]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            x    <= {1'b0, cmd.w1} + U1_OFFSET;
            w2   <= cmd.w2;
            k    <= 6'd31;
            frac <= '0;
            zero_out <= cmd.reseed;
            state <= cmd.reseed ? S_OUT : S_NORM;
          end
        end
        S_NORM: begin
          // Find top set bit one step a cycle; drop to zero if u1 >= 1.
          if (x[32]) begin
            zero_out <= 1'b1;
            state <= S_OUT;
          end else if (x[31] || k == 6'd0) begin
            m <= x;
            cnt <= 5'd0;
            state <= S_LOG;
          end else begin
            x <= {x[31:0], 1'b0};
            k <= k - 6'd1;
          end
        end
        S_LOG: begin
          frac <= {frac[22:0], m_sq[63]};
          m    <= m_sq[63] ? m_sq[63:31] >> 1 : m_sq[63:31];
          cnt  <= cnt + 5'd1;
          if (cnt == 5'(LOG_FRAC_BITS - 1)) state <= S_LOGFIN;
        end
        S_LOGFIN: begin
          t <= 30'({6'd32 - k, 24'd0} - {6'd0, frac});
          state <= S_RAD;
        end
        S_RAD: begin
          r2  <= {2'b00, t_mul[59:30], 24'd0};
          rem <= '0;
          res <= '0;
          cnt <= 5'd0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          // Bit-serial root of r2 * 2^24: two radicand bits a cycle.
          if ({res, 2'b01} <= trial[30:0] && trial[57:31] == 0 ||
              {27'd0, res, 2'b01} <= trial) begin
            rem <= 56'(trial - {27'd0, res, 2'b01});
            res <= {res[27:0], 1'b1};
          end else begin
            rem <= trial[55:0];
            res <= {res[27:0], 1'b0};
          end
          r2  <= {r2[53:0], 2'b00};
          if (cnt == 5'd27) begin
            cnt  <= 5'd0;
            cx   <= CORDIC_GAIN_Q24;
            cy   <= '0;
            cz   <= 28'(th_mul[54:30]);
            quad <= w2[31:30];
            state <= S_CORDIC;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_CORDIC: begin
          if (!cz[27]) begin
            cx <= cx - sy;
            cy <= cy + sx;
            cz <= cz - atan_q24(cnt);
          end else begin
            cx <= cx + sy;
            cy <= cy - sx;
            cz <= cz + atan_q24(cnt);
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(CORDIC_ITERS - 1)) state <= S_MUL;
        end
        S_MUL: begin
          case (quad)
            2'd0: begin cabs <= cx[27] ? 28'(-cx) : cx; cneg <= cx[27]; end
            2'd1: begin cabs <= cy[27] ? 28'(-cy) : cy; cneg <= !cy[27] && cy != 0; end
            2'd2: begin cabs <= cx[27] ? 28'(-cx) : cx; cneg <= !cx[27] && cx != 0; end
            default: begin cabs <= cy[27] ? 28'(-cy) : cy; cneg <= cy[27]; end
          endcase
          state <= S_RND;
        end
        S_RND: begin
          prod  <= 57'(res) * 57'(cabs) + (57'd1 << 35);
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold the finished sample here until the output register is free.
          if (!res_valid || res_ready) begin
            res_sample <= out_val;
            res_valid  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (res_valid && res_ready && state != S_OUT) res_valid <= 1'b0;
    end
  end

endmodule

[hdl/gaussian_noise_generator_core.sv]
// Path: a draw passes the front holding register and the queue; the back end
// then runs normalization, 24 log squarings, 28 square-root steps, 20 CORDIC
// steps and fixed states; top-of-range u1 and reseed skip to the output state.
// Flow: the back end's shared sequencer takes a command only when idle, one
// item at a time; the queue holds two. The front steps the generator at once.
// Reset: synchronous active-high rst; generator word 42, queue empty.
// ----------------------------------------------------------------------------
// gaussian_noise_generator_core: Box-Muller gaussian source over an LCG
// Front end steps the LCG, a short queue decouples, back end computes.
// ----------------------------------------------------------------------------
module gaussian_noise_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic [31:0]        seed_value,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample
);
  import gng_pkg::*;

  gng_cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready, r_valid;
  logic [15:0] r_sample;

  // Front: accept the beat and step the generator.
  gng_front u_front (
    .clk, .rst, .push, .full, .op, .seed_value,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  // Queue: hold commands while the back end works.
  gng_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  // Back: compute the sample, hold it until popped.
  gng_back u_back (
    .clk, .rst, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(r_valid), .res_ready(pop), .res_sample(r_sample)
  );

  assign empty  = !r_valid;
  assign sample = r_sample;

  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && q_ready) |=> empty)
    else $error("result not retired after pop");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sample)))
    else $error("waiting result changed");
endmodule
